// File: src/vgrc_pkg.sv
// Shared types and constants of the voxel grid ray caster.
package vgrc_pkg;

	// Transaction kinds carried in the input tuser field
	localparam logic [1:0] OP_RENDER = 2'd0;
	localparam logic [1:0] OP_PICK   = 2'd1;
	localparam logic [1:0] OP_WRITE  = 2'd2;

	localparam int OP_W     = 2;
	localparam int IN_DW    = 120;
	localparam int OUT_DW   = 64;
	localparam int COORD_W  = 10;
	localparam int DIST_W   = 30;
	localparam int REACH_W  = 20;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;

	localparam logic [DIST_W-1:0]  DIST_SAT = 30'h3FFF_FFFF;
	localparam logic [REACH_W-1:0] OUT_SAT  = 20'hF_FFFF;
	localparam logic [REACH_W-1:0] REACH_RESET = 20'd20480;

	// Register index of max_reach, taken from paddr[2]
	localparam logic REG_MAX_REACH = 1'b0;

	// Divider runs one quotient bit a cycle over 2^25 / |dir|
	localparam logic [4:0] DIV_TOP = 5'd25;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_STEP,
		ST_TEST,
		ST_SHADE,
		ST_SHADE_W,
		ST_WR,
		ST_WR_HT,
		ST_SCAN,
		ST_SCAN_W,
		ST_DONE
	} state_t;

endpackage

// File: src/voxel_grid_ray_caster.sv
// Voxel grid ray caster: voxel and column-height memories, divider setup and DDA walk.
// Steps: a cast sets up each axis (serial divider, then one multiply), then steps and tests
// each visited cell, reads a column height on a hit and loads the result. A write stores the
// voxel and column height (outside the grid just the result); a clearing write rescans cells.
// Throughput: one transaction at a time; input is taken again once the result is registered.
// Reset: a clearing pass zeroes both memories, s_tready low.
module voxel_grid_ray_caster #(
	parameter int GRID_X = 32,
	parameter int GRID_Y = 32,
	parameter int GRID_Z = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, cell_x, cell_y, cell_z, material
	input  logic [vgrc_pkg::IN_DW-1:0]    s_tdata,
	// op
	input  logic [vgrc_pkg::OP_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// hit, hit_x, hit_y, hit_z, face, hit_material, shaded, before_x, before_y, before_z,
	// hit_distance
	output logic [vgrc_pkg::OUT_DW-1:0]   m_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vgrc_pkg::APB_AW-1:0]   paddr,
	input  logic [vgrc_pkg::APB_DW-1:0]   pwdata,
	output logic [vgrc_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import vgrc_pkg::*;

	localparam int NVOX = GRID_X * GRID_Y * GRID_Z;
	localparam int NCOL = GRID_X * GRID_Y;
	localparam int AW   = $clog2(NVOX);
	localparam int CAW  = $clog2(NCOL);
	localparam int HW   = $clog2(GRID_Z);
	localparam int LIM  = GRID_X + GRID_Y + GRID_Z + 1;
	localparam int NW   = $clog2(LIM + 1);

	typedef logic signed [COORD_W-1:0] coord_t;

	state_t state_q, state_d;

	logic [AW-1:0]           clr_q;
	logic [REACH_W-1:0]      max_reach_q;
	logic                    m_tvalid_q;
	logic [OUT_DW-1:0]       m_tdata_q;

	logic [1:0]              op_q;
	logic [15:0]             org_q [3];
	logic [15:0]             dir_q [3];
	logic [4:0]              wx_q, wy_q, wz_q;
	logic [2:0]              wmat_q;
	logic [1:0]              axis_q;
	logic [4:0]              div_cnt_q;
	logic [15:0]             rem_q;
	logic [25:0]             quo_q;
	logic [DIST_W-1:0]       dl_q [3];
	logic [DIST_W-1:0]       sd_q [3];
	coord_t                  c_q [3];
	coord_t                  p_q [3];
	logic [DIST_W-1:0]       dist_q;
	logic [NW-1:0]           n_q;
	logic [2:0]              face_q;
	logic                    hit_q;
	logic [2:0]              hmat_q;
	logic                    shaded_q;
	logic [HW-1:0]           scan_q;

	// Memories and their registered read data
	logic [2:0]              vox_mem [NVOX];
	logic [HW-1:0]           ht_mem [NCOL];
	logic [2:0]              vox_rdata_q;
	logic [HW-1:0]           ht_rdata_q;
	logic                    vox_en, vox_we;
	logic [AW-1:0]           vox_addr;
	logic [2:0]              vox_wdata;
	logic                    ht_en, ht_we;
	logic [CAW-1:0]          ht_addr;
	logic [HW-1:0]           ht_wdata;

	function automatic logic [AW-1:0] vaddr(coord_t x, coord_t y, coord_t z);
		logic [AW-1:0] col;
		col = AW'($unsigned(x)) * AW'(GRID_Y) + AW'($unsigned(y));
		return col * AW'(GRID_Z) + AW'($unsigned(z));
	endfunction

	function automatic logic [CAW-1:0] caddr(coord_t x, coord_t y);
		return CAW'($unsigned(x)) * CAW'(GRID_Y) + CAW'($unsigned(y));
	endfunction

	// Input field unpack
	logic [4:0] in_cx, in_cy, in_cz;
	logic       in_grid, accept;
	assign in_cx   = s_tdata[100:96];
	assign in_cy   = s_tdata[105:101];
	assign in_cz   = s_tdata[110:106];
	assign in_grid = (9'(in_cx) < 9'(GRID_X)) && (9'(in_cy) < 9'(GRID_Y))
		&& (9'(in_cz) < 9'(GRID_Z));
	assign accept  = s_tvalid && s_tready;

	// Restoring divider step for 2^25 / |dir| of the current axis
	logic [15:0] div_d, mag;
	logic [16:0] rem_sh;
	logic        ge, mag_zero;
	logic [15:0] rem_nx;
	logic [25:0] quo_nx;
	assign div_d    = dir_q[axis_q];
	assign mag      = div_d[15] ? (~div_d + 16'd1) : div_d;
	assign mag_zero = (mag == 16'd0);
	assign rem_sh   = {rem_q, div_cnt_q == DIV_TOP};
	assign ge       = rem_sh >= {1'b0, mag};
	assign rem_nx   = ge ? 16'(rem_sh - {1'b0, mag}) : rem_sh[15:0];
	assign quo_nx   = {quo_q[24:0], ge};

	// Initial side distance of the current axis, saturated delta included
	logic [9:0]  frac;
	logic [10:0] fmul;
	logic [40:0] prod;
	assign frac = org_q[axis_q][9:0];
	assign fmul = div_d[15] ? {1'b0, frac} : 11'd1024 - {1'b0, frac};
	assign prod = 41'(fmul) * 41'(dl_q[axis_q]);

	// DDA axis choice and advance
	logic [1:0]        ax;
	logic [DIST_W:0]   sum;
	logic [DIST_W-1:0] sd_new;
	coord_t            c_new [3];
	logic              out_grid, stop, pick;
	always_comb begin
		if (sd_q[0] < sd_q[1] && sd_q[0] < sd_q[2]) begin
			ax = 2'd0;
		end else if (sd_q[1] < sd_q[2]) begin
			ax = 2'd1;
		end else begin
			ax = 2'd2;
		end
		sum    = {1'b0, sd_q[ax]} + {1'b0, dl_q[ax]};
		sd_new = (sum > {1'b0, DIST_SAT}) ? DIST_SAT : sum[DIST_W-1:0];
		c_new  = c_q;
		c_new[ax] = dir_q[ax][15] ? c_q[ax] - coord_t'(1) : c_q[ax] + coord_t'(1);
	end
	assign out_grid = c_new[0] < 0 || c_new[0] >= coord_t'(GRID_X)
		|| c_new[1] < 0 || c_new[1] >= coord_t'(GRID_Y)
		|| c_new[2] < 0 || c_new[2] >= coord_t'(GRID_Z);
	assign pick = (op_q == OP_PICK);
	assign stop = (n_q == NW'(LIM)) || (pick && !(dist_q < DIST_W'(max_reach_q)));

	// Neighbor column for shading
	coord_t nx, ny;
	logic   sh_ok;
	always_comb begin
		nx = c_q[0];
		ny = c_q[1];
		case (face_q)
			3'd0: begin
				nx    = c_q[0] - coord_t'(1);
				sh_ok = c_q[0] > 0;
			end
			3'd1: begin
				nx    = c_q[0] + coord_t'(1);
				sh_ok = c_q[0] < coord_t'(GRID_X - 1);
			end
			3'd2: begin
				ny    = c_q[1] - coord_t'(1);
				sh_ok = c_q[1] > 0;
			end
			3'd3: begin
				ny    = c_q[1] + coord_t'(1);
				sh_ok = c_q[1] < coord_t'(GRID_Y - 1);
			end
			3'd4: begin
				sh_ok = 1'b0;
			end
			default: begin
				sh_ok = c_q[2] < coord_t'(GRID_Z - 1);
			end
		endcase
	end

	// Column update values for writes
	logic [HW-1:0] ht_max, ht_scan;
	logic          scan_end;
	assign ht_max   = (HW'(wz_q) > ht_rdata_q) ? HW'(wz_q) : ht_rdata_q;
	assign ht_scan  = (vox_rdata_q != 3'd0) ? scan_q : '0;
	assign scan_end = (vox_rdata_q != 3'd0) || (scan_q == '0);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == AW'(NVOX - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == OP_RENDER || s_tuser == OP_PICK) begin
						state_d = ST_DIV;
					end else if (s_tuser == OP_WRITE && in_grid) begin
						state_d = ST_WR;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DIV:     if (div_cnt_q == 5'd0) state_d = ST_MUL;
			ST_MUL:     state_d = (axis_q == 2'd2) ? ST_STEP : ST_DIV;
			ST_STEP:    state_d = (stop || out_grid) ? ST_DONE : ST_TEST;
			ST_TEST:    state_d = (vox_rdata_q != 3'd0) ? ST_SHADE : ST_STEP;
			ST_SHADE:   state_d = ST_SHADE_W;
			ST_SHADE_W: state_d = ST_DONE;
			ST_WR:      state_d = ST_WR_HT;
			ST_WR_HT:   state_d = (wmat_q != 3'd0) ? ST_DONE : ST_SCAN;
			ST_SCAN:    state_d = ST_SCAN_W;
			ST_SCAN_W:  if (scan_end) state_d = ST_DONE; else state_d = ST_SCAN;
			ST_DONE:    if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Memory port controls and input ready
	always_comb begin
		s_tready  = 1'b0;
		vox_en    = 1'b0;
		vox_we    = 1'b0;
		vox_addr  = '0;
		vox_wdata = '0;
		ht_en     = 1'b0;
		ht_we     = 1'b0;
		ht_addr   = '0;
		ht_wdata  = '0;
		case (state_q)
			ST_CLEAR: begin
				vox_en   = 1'b1;
				vox_we   = 1'b1;
				vox_addr = clr_q;
				ht_en    = clr_q < AW'(NCOL);
				ht_we    = clr_q < AW'(NCOL);
				ht_addr  = CAW'(clr_q);
			end
			ST_IDLE: s_tready = 1'b1;
			ST_STEP: begin
				vox_en   = !stop && !out_grid;
				vox_addr = vaddr(c_new[0], c_new[1], c_new[2]);
			end
			ST_SHADE: begin
				ht_en   = 1'b1;
				ht_addr = sh_ok ? caddr(nx, ny) : '0;
			end
			ST_WR: begin
				vox_en    = 1'b1;
				vox_we    = 1'b1;
				vox_addr  = vaddr(coord_t'(wx_q), coord_t'(wy_q), coord_t'(wz_q));
				vox_wdata = wmat_q;
				ht_en     = 1'b1;
				ht_addr   = caddr(coord_t'(wx_q), coord_t'(wy_q));
			end
			ST_WR_HT: begin
				ht_en    = wmat_q != 3'd0;
				ht_we    = wmat_q != 3'd0;
				ht_addr  = caddr(coord_t'(wx_q), coord_t'(wy_q));
				ht_wdata = ht_max;
			end
			ST_SCAN: begin
				vox_en   = 1'b1;
				vox_addr = vaddr(coord_t'(wx_q), coord_t'(wy_q), coord_t'(scan_q));
			end
			ST_SCAN_W: begin
				ht_en    = scan_end;
				ht_we    = scan_end;
				ht_addr  = caddr(coord_t'(wx_q), coord_t'(wy_q));
				ht_wdata = ht_scan;
			end
			default: ;
		endcase
	end

	// Voxel memory, one port
	always_ff @(posedge clk) begin
		if (vox_en) begin
			if (vox_we) begin
				vox_mem[vox_addr] <= vox_wdata;
			end else begin
				vox_rdata_q <= vox_mem[vox_addr];
			end
		end
	end

	// Column height memory, one port
	always_ff @(posedge clk) begin
		if (ht_en) begin
			if (ht_we) begin
				ht_mem[ht_addr] <= ht_wdata;
			end else begin
				ht_rdata_q <= ht_mem[ht_addr];
			end
		end
	end

	// Result fields
	logic              is_cast, rh, rb;
	logic [REACH_W-1:0] dist_out;
	assign is_cast  = (op_q == OP_RENDER) || (op_q == OP_PICK);
	assign rh       = hit_q && is_cast;
	assign rb       = rh && pick;
	assign dist_out = !is_cast ? '0
		: (dist_q > DIST_W'(OUT_SAT)) ? OUT_SAT : dist_q[REACH_W-1:0];

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			max_reach_q <= REACH_RESET;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (psel && penable && pwrite && paddr[2] == REG_MAX_REACH) begin
				max_reach_q <= pwdata[REACH_W-1:0];
			end
			if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q   <= s_tuser;
					org_q  <= '{s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]};
					dir_q  <= '{s_tdata[63:48], s_tdata[79:64], s_tdata[95:80]};
					c_q    <= '{coord_t'(s_tdata[15:10]), coord_t'(s_tdata[31:26]),
						coord_t'(s_tdata[47:42])};
					p_q    <= '{coord_t'(s_tdata[15:10]), coord_t'(s_tdata[31:26]),
						coord_t'(s_tdata[47:42])};
					wx_q   <= in_cx;
					wy_q   <= in_cy;
					wz_q   <= in_cz;
					wmat_q <= s_tdata[113:111];
					hit_q  <= (s_tuser == OP_WRITE) && in_grid;
					axis_q    <= 2'd0;
					div_cnt_q <= DIV_TOP;
					rem_q     <= '0;
					dist_q    <= '0;
					n_q       <= '0;
					face_q    <= '0;
					hmat_q    <= '0;
					shaded_q  <= 1'b0;
					scan_q    <= HW'(GRID_Z - 1);
				end
			end
			ST_DIV: begin
				rem_q     <= rem_nx;
				quo_q     <= quo_nx;
				div_cnt_q <= div_cnt_q - 5'd1;
				if (div_cnt_q == 5'd0) begin
					dl_q[axis_q] <= mag_zero ? DIST_SAT : DIST_W'(quo_nx);
				end
			end
			ST_MUL: begin
				sd_q[axis_q] <= DIST_W'(prod >> 10);
				axis_q       <= axis_q + 2'd1;
				div_cnt_q    <= DIV_TOP;
				rem_q        <= '0;
			end
			ST_STEP: begin
				if (!stop) begin
					p_q      <= c_q;
					dist_q   <= sd_q[ax];
					sd_q[ax] <= sd_new;
					c_q      <= c_new;
					n_q      <= n_q + NW'(1);
					face_q   <= {ax, 1'b0} + {2'b0, dir_q[ax][15]};
				end
			end
			ST_TEST: begin
				if (vox_rdata_q != 3'd0) begin
					hit_q  <= 1'b1;
					hmat_q <= vox_rdata_q;
				end
			end
			ST_SHADE_W: begin
				shaded_q <= (face_q == 3'd4)
					|| (sh_ok && $unsigned(c_q[2]) < COORD_W'(ht_rdata_q));
			end
			ST_SCAN_W: scan_q <= scan_q - HW'(1);
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {6'b0, dist_out,
						rb ? p_q[2][4:0] : 5'd0, rb ? p_q[1][4:0] : 5'd0,
						rb ? p_q[0][4:0] : 5'd0,
						rh && shaded_q, rh ? hmat_q : 3'd0, rh ? face_q : 3'd0,
						rh ? c_q[2][4:0] : 5'd0, rh ? c_q[1][4:0] : 5'd0,
						rh ? c_q[0][4:0] : 5'd0, hit_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign pready   = 1'b1;
	assign prdata   = {{(APB_DW - REACH_W){1'b0}}, max_reach_q};

endmodule

// File: src/vgrc_checker.sv
// Port-level checks for the voxel grid ray caster, bound to the top level.
module vgrc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [vgrc_pkg::OUT_DW-1:0] m_tdata,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [vgrc_pkg::APB_AW-1:0] paddr,
	input logic [vgrc_pkg::APB_DW-1:0] pwdata,
	input logic [vgrc_pkg::APB_DW-1:0] prdata
);
	import vgrc_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Read back a register write
	a_reach_rd: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[2] == REG_MAX_REACH
		|=> prdata == {12'b0, $past(pwdata[19:0])})
		else $error("max_reach read back mismatch");

	// Clear cell fields on a miss
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[37:1] == 37'd0)
		else $error("miss carries cell fields");

	// Keep face codes in range
	a_face: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[18:16] <= 3'd5)
		else $error("face code out of range");

	// Shade a bottom face
	a_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] && m_tdata[18:16] == 3'd4 |-> m_tdata[22])
		else $error("bottom face not shaded");

endmodule

bind voxel_grid_ray_caster vgrc_checker u_vgrc_checker (.*);

// File: tb/sv/tb.sv
// Testbench for the voxel grid ray caster: stream stimulus, in-line predictor, result checker.
`timescale 1ns / 1ps

module tb;
	import vgrc_pkg::*;

	localparam int GX = 32;
	localparam int GY = 32;
	localparam int GZ = 24;
	localparam int WATCH_LIMIT = 120000;
	localparam logic [1:0] OP_NONE = 2'd3;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_DW-1:0]    s_tdata;
	logic [OP_W-1:0]     s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_DW-1:0]   m_tdata;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	voxel_grid_ray_caster uut (.*);

	// Mirror of the block state
	bit [2:0]          grid_mat [GX][GY][GZ];
	bit [4:0]          col_top [GX][GY];
	bit [REACH_W-1:0]  reach_lim;
	logic [OUT_DW-1:0] result_q [$];

	int  err_cnt = 0;
	int  n_items = 0;
	int  n_results = 0;
	int  n_hits = 0;
	bit  send_idle = 1;
	bit  recv_stall = 1;
	int  quiet_cycles = 0;

	// Result field layout, lowest bit first
	int    fld_lsb [11] = '{0, 1, 6, 11, 16, 19, 22, 23, 28, 33, 38};
	int    fld_w   [11] = '{1, 5, 5, 5, 3, 3, 1, 5, 5, 5, 20};
	string fld_nm  [11] = '{"hit", "hit_x", "hit_y", "hit_z", "face", "hit_material",
		"shaded", "before_x", "before_y", "before_z", "hit_distance"};

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [IN_DW-1:0] pack_in(int ox, int oy, int oz, int dx, int dy,
			int dz, int cx, int cy, int cz, int mat);
		logic [IN_DW-1:0] v;
		v = '0;
		v[15:0] = ox[15:0];
		v[31:16] = oy[15:0];
		v[47:32] = oz[15:0];
		v[63:48] = dx[15:0];
		v[79:64] = dy[15:0];
		v[95:80] = dz[15:0];
		v[100:96] = cx[4:0];
		v[105:101] = cy[4:0];
		v[110:106] = cz[4:0];
		v[113:111] = mat[2:0];
		return v;
	endfunction

	// Per-axis DDA setup: start cell, step, crossing increment, first crossing
	function automatic void axis_init(input logic [15:0] org, input logic [15:0] dir,
			output int cell_idx, output int stp, output longint dlt, output longint sd);
		longint mag;
		longint f;
		cell_idx = org[15:10];
		mag = dir[15] ? (65536 - longint'(dir)) : longint'(dir);
		dlt = (mag == 0) ? longint'(DIST_SAT) : ((longint'(1) << 25) / mag);
		stp = dir[15] ? -1 : 1;
		f = dir[15] ? longint'(org[9:0]) : (1024 - longint'(org[9:0]));
		sd = (f * dlt) >> 10;
		if (sd > longint'(DIST_SAT))
			sd = DIST_SAT;
	endfunction

	// Walk the ray and build the expected result word
	function automatic logic [OUT_DW-1:0] cast_ray(logic [IN_DW-1:0] d, bit pick);
		int c [3], st [3], pv [3];
		longint dl [3], sd [3];
		longint walk_dist;
		int a, fc, sh, x, y, z;
		bit hit;
		logic [OUT_DW-1:0] r;
		r = '0;
		hit = 0;
		fc = 0;
		walk_dist = 0;
		for (int i = 0; i < 3; i++)
			axis_init(d[16*i +: 16], d[48 + 16*i +: 16], c[i], st[i], dl[i], sd[i]);
		pv = c;
		for (int n = 0; n < GX + GY + GZ + 1; n++) begin
			if (pick && !(walk_dist < longint'(reach_lim)))
				break;
			pv = c;
			if (sd[0] < sd[1] && sd[0] < sd[2])
				a = 0;
			else if (sd[1] < sd[2])
				a = 1;
			else
				a = 2;
			walk_dist = sd[a];
			sd[a] = sd[a] + dl[a];
			if (sd[a] > longint'(DIST_SAT))
				sd[a] = DIST_SAT;
			c[a] += st[a];
			fc = 2*a + (st[a] > 0 ? 0 : 1);
			if (c[0] < 0 || c[0] >= GX || c[1] < 0 || c[1] >= GY || c[2] < 0 || c[2] >= GZ)
				break;
			if (grid_mat[c[0]][c[1]][c[2]] != 0) begin
				hit = 1;
				break;
			end
		end
		r[57:38] = (walk_dist > longint'(OUT_SAT)) ? OUT_SAT : walk_dist[19:0];
		if (hit) begin
			x = c[0];
			y = c[1];
			z = c[2];
			case (fc)
				0: sh = (x > 0 && z < col_top[x-1][y]);
				1: sh = (x < GX-1 && z < col_top[x+1][y]);
				2: sh = (y > 0 && z < col_top[x][y-1]);
				3: sh = (y < GY-1 && z < col_top[x][y+1]);
				4: sh = 1;
				default: sh = (z < GZ-1 && z < col_top[x][y]);
			endcase
			r[0] = 1;
			r[5:1] = x[4:0];
			r[10:6] = y[4:0];
			r[15:11] = z[4:0];
			r[18:16] = fc[2:0];
			r[21:19] = grid_mat[x][y][z];
			r[22] = sh[0];
			if (pick) begin
				r[27:23] = pv[0][4:0];
				r[32:28] = pv[1][4:0];
				r[37:33] = pv[2][4:0];
			end
		end
		return r;
	endfunction

	// Store a voxel and keep the column top up to date
	function automatic logic [OUT_DW-1:0] store_voxel(logic [IN_DW-1:0] d);
		int x, y, z;
		logic [2:0] m;
		x = d[100:96];
		y = d[105:101];
		z = d[110:106];
		m = d[113:111];
		if (x >= GX || y >= GY || z >= GZ)
			return '0;
		grid_mat[x][y][z] = m;
		if (m != 0) begin
			if (z > col_top[x][y])
				col_top[x][y] = z[4:0];
		end else begin
			col_top[x][y] = 0;
			for (int k = GZ-1; k >= 0; k--) begin
				if (grid_mat[x][y][k] != 0) begin
					col_top[x][y] = k[4:0];
					break;
				end
			end
		end
		return 64'd1;
	endfunction

	function automatic logic [OUT_DW-1:0] predict_result(logic [1:0] op, logic [IN_DW-1:0] d);
		case (op)
			OP_RENDER: return cast_ray(d, 0);
			OP_PICK:   return cast_ray(d, 1);
			OP_WRITE:  return store_voxel(d);
			default:   return '0;
		endcase
	endfunction

	// Send one transaction, with an optional random gap first
	task automatic send_item(input logic [1:0] op, input logic [IN_DW-1:0] d);
		int gap;
		gap = (send_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= d;
		do
			@(posedge clk);
		while (!s_tready);
		result_q.push_back(predict_result(op, d));
		n_items++;
	endtask

	task automatic drain();
		@(posedge clk);
		s_tvalid <= 0;
		while (result_q.size() != 0)
			@(posedge clk);
	endtask

	// Register write then read back, block idle
	task automatic set_reach(input int val);
		drain();
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= {REG_MAX_REACH, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		reach_lim = val[19:0];
		pwrite <= 0;
		penable <= 0;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		if (prdata[REACH_W-1:0] !== reach_lim) begin
			$display("%0t max_reach readback expected %0d actual %0d", $time, reach_lim,
				prdata[REACH_W-1:0]);
			err_cnt++;
		end
		psel <= 0;
		penable <= 0;
	endtask

	function automatic int cell_org(int idx);
		return idx * 1024 + 512;
	endfunction

	task automatic cast_at(input logic [1:0] op, input int cx, input int cy, input int cz,
			input int dx, input int dy, input int dz);
		send_item(op, pack_in(cell_org(cx), cell_org(cy), cell_org(cz), dx, dy, dz, 0, 0, 0, 0));
	endtask

	task automatic put_voxel(input int x, input int y, input int z, input int m);
		send_item(OP_WRITE, pack_in(0, 0, 0, 0, 0, 0, x, y, z, m));
	endtask

	// Empty grid: every cast misses, walk ends at the border or at the reach limit
	task automatic test_empty_grid();
		set_reach(20480);
		cast_at(OP_RENDER, 0, 0, 0, 8192, 0, 0);
		cast_at(OP_RENDER, 31, 31, 23, -8192, -4096, -100);
		cast_at(OP_PICK, 10, 10, 10, 0, 0, 0);
		send_item(OP_RENDER, pack_in(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 1,
			0, 0, 0, 0));
	endtask

	// Each face, shading, extremes, odd codes and out-of-grid writes
	task automatic test_faces_and_writes();
		put_voxel(5, 5, 5, 1);
		put_voxel(4, 5, 10, 2);
		put_voxel(6, 5, 9, 7);
		put_voxel(5, 4, 12, 3);
		put_voxel(31, 31, 23, 4);
		put_voxel(0, 0, 0, 5);
		put_voxel(3, 3, 30, 1);
		put_voxel(31, 31, 24, 2);
		cast_at(OP_RENDER, 2, 5, 5, 8192, 0, 0);
		cast_at(OP_RENDER, 9, 5, 5, -8192, 0, 0);
		cast_at(OP_PICK, 5, 2, 5, 0, 8192, 0);
		cast_at(OP_PICK, 5, 8, 5, 0, -8192, 0);
		cast_at(OP_RENDER, 5, 5, 1, 0, 0, 8192);
		cast_at(OP_PICK, 5, 5, 9, 0, 0, -8192);
		cast_at(OP_RENDER, 3, 3, 3, 4096, 4096, 4096);
		cast_at(OP_PICK, 1, 1, 1, -8192, -8192, -8192);
		put_voxel(4, 5, 10, 0);
		put_voxel(5, 5, 5, 0);
		cast_at(OP_RENDER, 2, 5, 5, 8192, 0, 0);
		send_item(OP_NONE, {IN_DW{1'b1}});
	endtask

	// Reach limit at its extremes and in between
	task automatic test_reach_limit();
		int vals [4] = '{0, 1048575, 4096, 20480};
		put_voxel(20, 10, 10, 1);
		foreach (vals[i]) begin
			set_reach(vals[i]);
			cast_at(OP_PICK, 12, 10, 10, 8192, 0, 0);
			cast_at(OP_PICK, 18, 10, 10, 8192, 0, 0);
			cast_at(OP_PICK, 19, 10, 10, 1, 0, 0);
		end
	endtask

	function automatic int rand_dir();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return $urandom_range(0, 64) - 32;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	// Mostly in-grid writes and casts, some raw noise
	task automatic test_random(input int count);
		int sel;
		logic [IN_DW-1:0] d;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				put_voxel($urandom_range(0, 31), $urandom_range(0, 31),
					($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23),
					($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7));
			end else if (sel < 95) begin
				d = pack_in($urandom_range(0, 32767), $urandom_range(0, 32767),
					$urandom_range(0, 24575), rand_dir(), rand_dir(), rand_dir(), 0, 0, 0, 0);
				send_item((sel < 70) ? OP_RENDER : OP_PICK, d);
			end else begin
				d = IN_DW'({$urandom, $urandom, $urandom, $urandom});
				send_item(2'($urandom_range(0, 3)), d);
			end
		end
	endtask

	// Reply side backpressure in random bursts
	initial begin
		m_tready = 0;
		forever begin
			if (recv_stall && $urandom_range(0, 2) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				m_tready <= 1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		logic [OUT_DW-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (result_q.size() == 0) begin
				$display("%0t unexpected result expected none actual %h", $time, m_tdata);
				err_cnt++;
			end else begin
				want = result_q.pop_front();
				if (want[0])
					n_hits++;
				for (int f = 0; f < 11; f++) begin
					if ((m_tdata >> fld_lsb[f]) % (64'd1 << fld_w[f]) !==
							(want >> fld_lsb[f]) % (64'd1 << fld_w[f])) begin
						$display("%0t %s expected %0d actual %0d", $time, fld_nm[f],
							(want >> fld_lsb[f]) % (64'd1 << fld_w[f]),
							(m_tdata >> fld_lsb[f]) % (64'd1 << fld_w[f]));
						err_cnt++;
					end
				end
			end
		end
	end

	// Stop when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		reach_lim = REACH_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		test_empty_grid();
		test_faces_and_writes();
		test_reach_limit();
		set_reach($urandom_range(0, 1048575));
		test_random(500);
		set_reach(1048575);
		test_random(500);
		set_reach($urandom_range(1024, 40960));
		test_random(500);
		drain();
		send_idle = 0;
		recv_stall = 0;
		test_random(450);
		drain();
		repeat (300) @(posedge clk);
		$display("Covered %0d items: writes, render and pick casts, reach limits; %0d results,",
			n_items, n_results);
		$display("of which %0d flagged hit or write acknowledge.", n_hits);
		if (err_cnt == 0 && result_q.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
